// ===== rtl/owscc_pkg.sv =====
// ----------------------------------------------------------------------------
// owscc_pkg
// Shared types, register codes, constants and direction tables for the
// omni wheel step command converter.
// ----------------------------------------------------------------------------
package owscc_pkg;

  // fixed point fraction bits of the internal arithmetic
  localparam int unsigned FracBits = 16;

  // configuration register widths
  localparam int unsigned WheelDiamW = 10;
  localparam int unsigned BaseDiamW  = 12;
  localparam int unsigned MicrostepW = 9;
  localparam int unsigned BaseClkW   = 27;
  localparam int unsigned CfgDataW   = 27;
  localparam int unsigned CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHEEL_DIAM = 2'd0,
    CFG_BASE_DIAM  = 2'd1,
    CFG_MICROSTEP  = 2'd2,
    CFG_BASE_CLK   = 2'd3
  } cfg_reg_e;

  localparam logic [WheelDiamW-1:0] WheelDiamRst = 10'd60;
  localparam logic [BaseDiamW-1:0]  BaseDiamRst  = 12'd250;
  localparam logic [MicrostepW-1:0] MicrostepRst = 9'd16;
  localparam logic [BaseClkW-1:0]   BaseClkRst   = 27'd1000000;

  // full steps per revolution and rotation scaling
  localparam int unsigned FullSteps  = 200;
  localparam int unsigned HalfCircle = 180;

  // 1/pi and sqrt(3)/2 in Q0.32, rounded to nearest Q0.FracBits
  localparam logic [63:0] InvPiQ32     = 64'd1367130551;
  localparam logic [63:0] HalfSqrt3Q32 = 64'd3719550786;
  localparam logic [FracBits-1:0] InvPi =
    FracBits'((InvPiQ32 + (64'd1 << (31 - FracBits))) >> (32 - FracBits));
  localparam logic [FracBits-1:0] HalfSqrt3 =
    FracBits'((HalfSqrt3Q32 + (64'd1 << (31 - FracBits))) >> (32 - FracBits));

  // direction codes
  localparam logic [3:0] DirFirst  = 4'd1;
  localparam logic [3:0] DirRotCcw = 4'd7;
  localparam logic [3:0] DirRotCw  = 4'd8;

  // per code 1..8: spin bits and active wheels, bit i is wheel i
  localparam logic [2:0] SpinTab [8] = '{3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1, 3'd7, 3'd0};
  localparam logic [2:0] ActTab  [8] = '{3'd6, 3'd3, 3'd5, 3'd6, 3'd3, 3'd5, 3'd7, 3'd7};

  typedef struct packed {
    logic [3:0]  direction_code;
    logic [15:0] distance;
    logic [15:0] speed;
  } cmd_in_t;

  typedef struct packed {
    logic [31:0] step_count;
    logic [31:0] divider_wheel0;
    logic [31:0] divider_wheel1;
    logic [31:0] divider_wheel2;
    logic        spin_wheel0;
    logic        spin_wheel1;
    logic        spin_wheel2;
    logic        bad_direction;
  } cmd_out_t;

endpackage

// ===== rtl/omni_wheel_step_command_convert.sv =====
// throughput: one command per cycle, every stage holds when the result is stalled
// the two long divisions are one quotient bit per stage, so the pq divider
//   (62 stages) and the step divider (40) set the depth
// reset: all stage valid bits cleared, configuration back to defaults
// ----------------------------------------------------------------------------
// omni_wheel_step_command_convert
// Converts a motion command into per-wheel step dividers, spin bits and a
// step count through a fully pipelined fixed point datapath.
// ----------------------------------------------------------------------------
module omni_wheel_step_command_convert (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [owscc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [owscc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  owscc_pkg::cmd_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output owscc_pkg::cmd_out_t                  out_data_o
);

  localparam int unsigned F    = owscc_pkg::FracBits;
  localparam int unsigned DW   = owscc_pkg::WheelDiamW;
  localparam int unsigned FbW  = owscc_pkg::BaseClkW;
  localparam int unsigned SW   = 17;            // steps per revolution
  localparam int unsigned AW   = 16 + SW;       // speed or distance times steps
  localparam int unsigned CW   = owscc_pkg::BaseDiamW + 16;
  localparam int unsigned RW   = CW + SW;       // base diameter * distance * steps
  localparam int unsigned FnW  = AW + 1;        // freq numerator after scaling
  localparam int unsigned PnW  = RW + F + 1;    // pq numerator and quotient
  localparam int unsigned PdW  = 18;            // 180 times wheel diameter
  localparam int unsigned FqW  = 32;            // step frequency
  localparam int unsigned DnW  = 33;            // divider numerator
  localparam int unsigned NqW  = 40;            // step quotient bits below the cap
  localparam int unsigned ProdW = PnW + FbW + 1;
  localparam int unsigned NnW  = ProdW - F;
  localparam int unsigned HW   = NnW - NqW;
  localparam int unsigned NlW  = 17;            // low part of an unsaturated step count
  localparam int unsigned NhW  = 16;            // high part of an unsaturated step count
  localparam int unsigned M5W  = 36;
  localparam int unsigned LoW  = 32 + FbW;
  localparam int unsigned HiW  = PnW - 32 + FbW;
  localparam int unsigned LAT  = 2 + (PnW + 1) + 2 + (NqW + 1) + 1 + 1;

  // ceil(2^38/5): floor(4n/5) is floor(n*Recip5/2^36) while 4n stays below 2^38
  localparam logic [M5W-1:0] Recip5 = 36'd54975581389;

  typedef struct packed {
    logic       bad;
    logic       rot;
    logic [2:0] act;
    logic [2:0] spin;
  } misc_t;

  typedef struct packed {
    misc_t          ctl;
    logic [DW-1:0]  frem;
    logic [FnW-1:0] fnq;
    logic [PdW-1:0] prem;
    logic [PnW-1:0] pnq;
  } p1_t;

  typedef struct packed {
    misc_t          ctl;
    logic           fzero;
    logic           cap;
    logic [FqW-1:0] fq;
    logic [FqW-1:0] nrem;
    logic [NqW-1:0] nnq;
    logic [FqW-1:0] drem;
    logic [DnW-1:0] dnq;
  } p2_t;

  typedef struct packed {
    misc_t              ctl;
    logic               fzero;
    logic [31:0]        div;
    logic [31:0]        rcnt;
    logic               tsat;
    logic [NlW+M5W-1:0] plo;
    logic [NhW+M5W-1:0] phi;
  } p3_t;

  // configuration
  logic [DW-1:0]                     wdiam_q;
  logic [owscc_pkg::BaseDiamW-1:0]   bdiam_q;
  logic [owscc_pkg::MicrostepW-1:0]  mstep_q;
  logic [FbW-1:0]                    fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdiam_q <= owscc_pkg::WheelDiamRst;
      bdiam_q <= owscc_pkg::BaseDiamRst;
      mstep_q <= owscc_pkg::MicrostepRst;
      fb_q    <= owscc_pkg::BaseClkRst;
    end else if (cfg_we_i) begin
      unique case (owscc_pkg::cfg_reg_e'(cfg_idx_i))
        owscc_pkg::CFG_WHEEL_DIAM: wdiam_q <= cfg_wdata_i[DW-1:0];
        owscc_pkg::CFG_BASE_DIAM:  bdiam_q <= cfg_wdata_i[owscc_pkg::BaseDiamW-1:0];
        owscc_pkg::CFG_MICROSTEP:  mstep_q <= cfg_wdata_i[owscc_pkg::MicrostepW-1:0];
        owscc_pkg::CFG_BASE_CLK:   fb_q    <= cfg_wdata_i[FbW-1:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0]  d_eff;
  logic [SW-1:0]  steps_rev;
  logic [PdW-1:0] d180;

  assign d_eff     = (wdiam_q == '0) ? DW'(1) : wdiam_q;
  assign steps_rev = SW'(mstep_q) * SW'(owscc_pkg::FullSteps);
  assign d180      = PdW'(d_eff) * PdW'(owscc_pkg::HalfCircle);

  // pipeline control
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv         = out_ready_i || !vld_q[LAT-1];
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // direction decode
  misc_t      dec;
  logic [2:0] dir_idx;

  always_comb begin
    dec.bad = (in_data_i.direction_code < owscc_pkg::DirFirst) ||
              (in_data_i.direction_code > owscc_pkg::DirRotCw);
    dec.rot = (in_data_i.direction_code == owscc_pkg::DirRotCcw) ||
              (in_data_i.direction_code == owscc_pkg::DirRotCw);
    dir_idx  = 3'(in_data_i.direction_code - owscc_pkg::DirFirst);
    dec.act  = dec.bad ? 3'd0 : owscc_pkg::ActTab[dir_idx];
    dec.spin = dec.bad ? 3'd0 : owscc_pkg::SpinTab[dir_idx];
  end

  // one restoring division step for pq, and for freq while fon
  function automatic p1_t p1_step(input p1_t s, input logic [PdW-1:0] pdiv,
                                  input logic [DW-1:0] fdiv, input logic fon);
    logic [PdW:0] pt;
    logic [DW:0]  ft;
    p1_t          r;
    r  = s;
    pt = {s.prem, s.pnq[PnW-1]};
    r.pnq = {s.pnq[PnW-2:0], 1'b0};
    if (pt >= {1'b0, pdiv}) begin
      r.prem   = PdW'(pt - {1'b0, pdiv});
      r.pnq[0] = 1'b1;
    end else begin
      r.prem = pt[PdW-1:0];
    end
    if (fon) begin
      ft    = {s.frem, s.fnq[FnW-1]};
      r.fnq = {s.fnq[FnW-2:0], 1'b0};
      if (ft >= {1'b0, fdiv}) begin
        r.frem   = DW'(ft - {1'b0, fdiv});
        r.fnq[0] = 1'b1;
      end else begin
        r.frem = ft[DW-1:0];
      end
    end
    return r;
  endfunction

  // one step of the step-count division, and of the divider while don
  function automatic p2_t p2_step(input p2_t s, input logic don);
    logic [FqW:0] t;
    p2_t          r;
    r = s;
    t = {s.nrem, s.nnq[NqW-1]};
    r.nnq = {s.nnq[NqW-2:0], 1'b0};
    if (t >= {1'b0, s.fq}) begin
      r.nrem   = FqW'(t - {1'b0, s.fq});
      r.nnq[0] = 1'b1;
    end else begin
      r.nrem = t[FqW-1:0];
    end
    if (don) begin
      t     = {s.drem, s.dnq[DnW-1]};
      r.dnq = {s.dnq[DnW-2:0], 1'b0};
      if (t >= {1'b0, s.fq}) begin
        r.drem   = FqW'(t - {1'b0, s.fq});
        r.dnq[0] = 1'b1;
      end else begin
        r.drem = t[FqW-1:0];
      end
    end
    return r;
  endfunction

  // front end products
  misc_t            e1_ctl_q, e2_ctl_q;
  logic [AW-1:0]    e1_a_q, e1_b_q;
  logic [CW-1:0]    e1_c_q;
  logic [AW+F-1:0]  e2_f_q, e2_pt_q;
  logic [RW-1:0]    e2_pr_q;

  // division pipelines
  p1_t p1_q [PnW+1];
  p1_t p1_nx [PnW];
  p2_t p2_q [NqW+1];
  p2_t p2_nx [NqW];
  p3_t p3_q;

  // middle products
  misc_t           e4_ctl_q, e5_ctl_q;
  logic [LoW-1:0]  e4_lo_q;
  logic [HiW-1:0]  e4_hi_q;
  logic [FbW+F-1:0] e4_fbr_q;
  logic [FqW-1:0]  e4_fq_q, e5_fq_q;
  logic [ProdW-1:0] e5_prod_q;
  logic [DnW-1:0]  e5_dnum_q;

  // stage entries
  logic [FnW+F-1:0] f_sum;
  logic [PnW-1:0]   p_num;
  p1_t              p1_in;
  logic [FqW-1:0]   freq;
  logic [PnW-1:0]   pq;
  logic [DnW+F:0]   d_sum;
  logic [DnW-1:0]   d_num;
  logic [ProdW-1:0] n_sum;
  logic [NnW-1:0]   n_num;
  logic [HW-1:0]    n_high;
  p2_t              p2_in;
  logic [NqW:0]     n_fin;
  logic [NqW+5:0]   n19;
  p3_t              p3_in;
  logic [NlW+NhW+M5W-1:0] q5_sum;
  logic [NlW+NhW-1:0] q5;
  owscc_pkg::cmd_out_t res;
  logic [31:0]      cnt;
  logic [31:0]      div_v;

  always_comb begin
    f_sum = (FnW+F)'(e2_f_q) + ((FnW+F)'(d_eff) << (F - 1));
    if (e2_ctl_q.rot) begin
      p_num = (PnW'(e2_pr_q) << F) + PnW'(d_eff) * PnW'(owscc_pkg::HalfCircle / 2);
    end else begin
      p_num = PnW'(e2_pt_q) + PnW'(d_eff >> 1);
    end
    p1_in.ctl  = e2_ctl_q;
    p1_in.frem = '0;
    p1_in.fnq  = f_sum[FnW+F-1:F];
    p1_in.prem = '0;
    p1_in.pnq  = p_num;

    freq = p1_q[PnW].fnq[FqW-1:0];
    pq   = p1_q[PnW].pnq;

    if (e4_ctl_q.rot) begin
      d_sum = '0;
      d_num = DnW'(fb_q) + DnW'(e4_fq_q >> 1);
    end else begin
      d_sum = (DnW+F+1)'(e4_fbr_q) + ((DnW+F+1)'(e4_fq_q) << (F - 1));
      d_num = d_sum[DnW+F-1:F];
    end

    n_sum  = e5_prod_q + (ProdW'(e5_fq_q) << (F - 1));
    n_num  = n_sum[ProdW-1:F];
    n_high = n_num[NnW-1:NqW];
    p2_in.ctl   = e5_ctl_q;
    p2_in.fzero = (e5_fq_q == '0);
    p2_in.cap   = (n_high >= HW'(e5_fq_q));
    p2_in.fq    = e5_fq_q;
    p2_in.nrem  = p2_in.cap ? '0 : n_high[FqW-1:0];
    p2_in.nnq   = n_num[NqW-1:0];
    p2_in.drem  = '0;
    p2_in.dnq   = e5_dnum_q;

    // step count held at 2^40 when the quotient would not fit
    n_fin = p2_q[NqW].cap ? {1'b1, NqW'(0)} : {1'b0, p2_q[NqW].nnq};
    n19   = (NqW+6)'(n_fin) * (NqW+6)'(19);
    p3_in.ctl   = p2_q[NqW].ctl;
    p3_in.fzero = p2_q[NqW].fzero;
    p3_in.div   = p2_q[NqW].dnq[31:0];
    p3_in.rcnt  = (n19[NqW+5:36] != '0) ? '1 : n19[35:4];
    p3_in.tsat  = (n_fin[NqW:NlW+NhW] != '0);
    p3_in.plo   = (NlW+M5W)'(n_fin[NlW-1:0]) * (NlW+M5W)'(Recip5);
    p3_in.phi   = (NhW+M5W)'(n_fin[NlW+NhW-1:NlW]) * (NhW+M5W)'(Recip5);

    // four fifths of the step count from the two partial products
    q5_sum = ((NlW+NhW+M5W)'(p3_q.phi) << NlW) + (NlW+NhW+M5W)'(p3_q.plo);
    q5     = q5_sum[NlW+NhW+M5W-1:M5W];

    if (p3_q.ctl.rot) begin
      cnt = p3_q.rcnt;
    end else begin
      cnt = (p3_q.tsat || q5[NlW+NhW-1]) ? '1 : q5[31:0];
    end
    div_v = p3_q.fzero ? '0 : p3_q.div;
    res   = '0;
    if (p3_q.ctl.bad) begin
      res.bad_direction = 1'b1;
    end else begin
      res.step_count     = p3_q.fzero ? '0 : cnt;
      res.divider_wheel0 = p3_q.ctl.act[0] ? div_v : '0;
      res.divider_wheel1 = p3_q.ctl.act[1] ? div_v : '0;
      res.divider_wheel2 = p3_q.ctl.act[2] ? div_v : '0;
      res.spin_wheel0    = p3_q.ctl.spin[0];
      res.spin_wheel1    = p3_q.ctl.spin[1];
      res.spin_wheel2    = p3_q.ctl.spin[2];
    end
  end

  always_comb begin
    for (int k = 0; k < PnW; k++) begin
      p1_nx[k] = p1_step(p1_q[k], p1_q[k].ctl.rot ? d180 : PdW'(d_eff), d_eff, (k < FnW));
    end
    for (int k = 0; k < NqW; k++) begin
      p2_nx[k] = p2_step(p2_q[k], (k < DnW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_ctl_q <= dec;
      e1_a_q   <= AW'(in_data_i.speed) * AW'(steps_rev);
      e1_b_q   <= AW'(in_data_i.distance) * AW'(steps_rev);
      e1_c_q   <= CW'(bdiam_q) * CW'(in_data_i.distance);

      e2_ctl_q <= e1_ctl_q;
      e2_f_q   <= (AW+F)'(e1_a_q) * (AW+F)'(owscc_pkg::InvPi);
      e2_pt_q  <= (AW+F)'(e1_b_q) * (AW+F)'(owscc_pkg::InvPi);
      e2_pr_q  <= RW'(e1_c_q) * RW'(steps_rev);

      p1_q[0] <= p1_in;
      for (int k = 0; k < PnW; k++) begin
        p1_q[k+1] <= p1_nx[k];
      end

      // pq times base clock split in two partial products
      e4_ctl_q <= p1_q[PnW].ctl;
      e4_lo_q  <= LoW'(pq[31:0]) * LoW'(fb_q);
      e4_hi_q  <= HiW'(pq[PnW-1:32]) * HiW'(fb_q);
      e4_fbr_q <= (FbW+F)'(fb_q) * (FbW+F)'(owscc_pkg::HalfSqrt3);
      e4_fq_q  <= freq;

      e5_ctl_q  <= e4_ctl_q;
      e5_prod_q <= (ProdW'(e4_hi_q) << 32) + ProdW'(e4_lo_q);
      e5_dnum_q <= d_num;
      e5_fq_q   <= e4_fq_q;

      p2_q[0] <= p2_in;
      for (int k = 0; k < NqW; k++) begin
        p2_q[k+1] <= p2_nx[k];
      end

      p3_q <= p3_in;

      out_data_o <= res;
    end
  end

`ifndef SYNTHESIS
  a_bad_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_direction |->
      out_data_o.step_count == '0 && out_data_o.divider_wheel0 == '0 &&
      out_data_o.divider_wheel1 == '0 && out_data_o.divider_wheel2 == '0 &&
      !out_data_o.spin_wheel0 && !out_data_o.spin_wheel1 && !out_data_o.spin_wheel2)
    else $error("bad direction result carries nonzero fields");

  a_div_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divider_wheel0 != '0 && out_data_o.divider_wheel1 != '0 |->
      out_data_o.divider_wheel0 == out_data_o.divider_wheel1)
    else $error("active wheel dividers differ");

  a_two_wheels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.divider_wheel0 != '0 || out_data_o.divider_wheel1 != '0 ||
      out_data_o.divider_wheel2 != '0) |->
      $countones({out_data_o.divider_wheel0 != '0, out_data_o.divider_wheel1 != '0,
                  out_data_o.divider_wheel2 != '0}) >= 2)
    else $error("fewer than two wheels driven");
`endif

endmodule
